// File: rtl/tccd_pkg.sv
`default_nettype none

package tccd_pkg;

    typedef enum logic [3:0] {
        EV_SAMPLE    = 4'd0,
        EV_VOLUME    = 4'd1,
        EV_REST      = 4'd2,
        EV_ENVELOPE  = 4'd3,
        EV_NOENV     = 4'd4,
        EV_PERIOD    = 4'd5,
        EV_NOTE      = 4'd6,
        EV_ORNAMENT  = 4'd7,
        EV_SLIDE     = 4'd8,
        EV_NOTESLIDE = 4'd9,
        EV_NOISE     = 4'd10,
        EV_TEMPO     = 4'd11,
        EV_TEMPO_ERR = 4'd12
    } t_event_kind;

    // Parse phase of one channel, kept one-hot in the state memory.
    typedef enum logic [3:0] {
        PH_OPCODE  = 4'b0001,
        PH_WORD_LO = 4'b0010,
        PH_WORD_HI = 4'b0100,
        PH_BYTE    = 4'b1000
    } t_phase;

    typedef struct packed {
        t_phase      phase;
        t_event_kind pending;
        logic [7:0]  low_byte;
        logic [3:0]  env_type;
        logic [4:0]  period;
    } t_chan_state;

    typedef struct packed {
        t_event_kind kind;
        logic [15:0] value;
        logic [3:0]  shape;
        logic [1:0]  channel;
        logic        row_end;
        logic [4:0]  row_period;
    } t_event;

    localparam t_chan_state STATE_RESET = '{
        phase:    PH_OPCODE,
        pending:  EV_SAMPLE,
        low_byte: 8'h00,
        env_type: 4'h0,
        period:   5'h00
    };

    localparam logic [7:0] OP_SAMPLE_LAST   = 8'h1F;
    localparam logic [7:0] OP_VOLUME_FIRST  = 8'h20;
    localparam logic [7:0] OP_VOLUME_LAST   = 8'h2F;
    localparam logic [7:0] OP_REST          = 8'h30;
    localparam logic [7:0] OP_ENV_LAST      = 8'h3E;
    localparam logic [7:0] OP_NOENV         = 8'h3F;
    localparam logic [7:0] OP_PERIOD_FIRST  = 8'h40;
    localparam logic [7:0] OP_PERIOD_LAST   = 8'h5F;
    localparam logic [7:0] OP_NOTE_FIRST    = 8'h60;
    localparam logic [7:0] OP_NOTE_LAST     = 8'hCB;
    localparam logic [7:0] OP_ORN_FIRST     = 8'hCC;
    localparam logic [7:0] OP_ORN_LAST      = 8'hEC;
    localparam logic [7:0] OP_SLIDE         = 8'hED;
    localparam logic [7:0] OP_NOTESLIDE     = 8'hEE;
    localparam logic [7:0] OP_NOISE         = 8'hEF;
    localparam logic [7:0] TEMPO_LOWEST     = 8'd3;

endpackage

`default_nettype wire

// File: rtl/tccd_state_mem.sv
`default_nettype none

module tccd_state_mem #(
    parameter int CHANNELS = 3,
    parameter int AW       = 2
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_rd_en,
    input  wire logic [AW-1:0]        i_rd_idx,
    input  wire logic                 i_wr_en,
    input  wire logic [AW-1:0]        i_wr_idx,
    input  wire tccd_pkg::t_chan_state i_wr_data,
    output tccd_pkg::t_chan_state     o_rd_data
);

    tccd_pkg::t_chan_state r_mem [CHANNELS];
    logic [CHANNELS-1:0]   r_written;
    tccd_pkg::t_chan_state r_rd_data;
    logic                  r_rd_written;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_idx] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_written <= '0;
        end else if (i_wr_en) begin
            r_written[i_wr_idx] <= 1'b1;
        end
    end

    // A write landing at the same edge as a read of the same entry is
    // forwarded into the read register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_written <= 1'b0;
        end else if (i_rd_en) begin
            if (i_wr_en && (i_wr_idx == i_rd_idx)) begin
                r_rd_written <= 1'b1;
            end else begin
                r_rd_written <= r_written[i_rd_idx];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            if (i_wr_en && (i_wr_idx == i_rd_idx)) begin
                r_rd_data <= i_wr_data;
            end else begin
                r_rd_data <= r_mem[i_rd_idx];
            end
        end
    end

    assign o_rd_data = r_rd_written ? r_rd_data : tccd_pkg::STATE_RESET;

endmodule

`default_nettype wire

// File: rtl/tccd_decode.sv
`default_nettype none

module tccd_decode (
    input  wire logic [7:0]           i_data_byte,
    input  wire logic [1:0]           i_channel,
    input  wire tccd_pkg::t_chan_state i_state,
    output tccd_pkg::t_chan_state     o_state,
    output logic                      o_emit,
    output tccd_pkg::t_event          o_event
);

    logic [7:0] b;
    logic [7:0] diff;
    tccd_pkg::t_event_kind kind;
    logic [15:0] value;
    logic [3:0]  shape;
    logic        row_end;

    assign b = i_data_byte;

    always_comb begin
        o_state = i_state;
        o_emit  = 1'b0;
        kind    = tccd_pkg::EV_SAMPLE;
        value   = 16'h0000;
        shape   = 4'h0;
        row_end = 1'b0;
        diff    = 8'h00;
        case (i_state.phase)
            tccd_pkg::PH_WORD_LO: begin
                o_state.low_byte = b;
                o_state.phase    = tccd_pkg::PH_WORD_HI;
            end
            tccd_pkg::PH_WORD_HI: begin
                o_state.phase = tccd_pkg::PH_OPCODE;
                o_emit        = 1'b1;
                kind          = i_state.pending;
                value         = {b, i_state.low_byte};
                if (i_state.pending == tccd_pkg::EV_ENVELOPE) begin
                    shape = i_state.env_type;
                end
            end
            tccd_pkg::PH_BYTE: begin
                o_state.phase = tccd_pkg::PH_OPCODE;
                o_emit        = 1'b1;
                kind          = i_state.pending;
                value         = {8'h00, b};
                if (i_state.pending == tccd_pkg::EV_TEMPO && b < tccd_pkg::TEMPO_LOWEST) begin
                    kind = tccd_pkg::EV_TEMPO_ERR;
                end
            end
            default: begin
                if (b inside {[8'h00:tccd_pkg::OP_SAMPLE_LAST]}) begin
                    o_emit = 1'b1;
                    kind   = tccd_pkg::EV_SAMPLE;
                    value  = {8'h00, b};
                end else if (b inside {[tccd_pkg::OP_VOLUME_FIRST:tccd_pkg::OP_VOLUME_LAST]}) begin
                    diff   = b - tccd_pkg::OP_VOLUME_FIRST;
                    o_emit = 1'b1;
                    kind   = tccd_pkg::EV_VOLUME;
                    value  = {8'h00, diff};
                end else if (b == tccd_pkg::OP_REST) begin
                    o_state.period = 5'h00;
                    o_emit         = 1'b1;
                    kind           = tccd_pkg::EV_REST;
                    row_end        = 1'b1;
                end else if (b <= tccd_pkg::OP_ENV_LAST) begin
                    // Envelope type is the opcode minus 0x30, i.e. its low nibble.
                    o_state.env_type = b[3:0];
                    o_state.pending  = tccd_pkg::EV_ENVELOPE;
                    o_state.phase    = tccd_pkg::PH_WORD_LO;
                end else if (b == tccd_pkg::OP_NOENV) begin
                    o_emit = 1'b1;
                    kind   = tccd_pkg::EV_NOENV;
                end else if (b <= tccd_pkg::OP_PERIOD_LAST) begin
                    diff           = b - tccd_pkg::OP_PERIOD_FIRST;
                    o_state.period = diff[4:0];
                    o_emit         = 1'b1;
                    kind           = tccd_pkg::EV_PERIOD;
                    value          = {8'h00, diff};
                    row_end        = 1'b1;
                end else if (b <= tccd_pkg::OP_NOTE_LAST) begin
                    diff           = b - tccd_pkg::OP_NOTE_FIRST;
                    o_state.period = 5'h00;
                    o_emit         = 1'b1;
                    kind           = tccd_pkg::EV_NOTE;
                    value          = {8'h00, diff};
                    row_end        = 1'b1;
                end else if (b <= tccd_pkg::OP_ORN_LAST) begin
                    diff   = b - tccd_pkg::OP_ORN_FIRST;
                    o_emit = 1'b1;
                    kind   = tccd_pkg::EV_ORNAMENT;
                    value  = {8'h00, diff};
                end else if (b == tccd_pkg::OP_SLIDE) begin
                    o_state.pending = tccd_pkg::EV_SLIDE;
                    o_state.phase   = tccd_pkg::PH_WORD_LO;
                end else begin
                    if (b == tccd_pkg::OP_NOTESLIDE) begin
                        o_state.pending = tccd_pkg::EV_NOTESLIDE;
                    end else if (b == tccd_pkg::OP_NOISE) begin
                        o_state.pending = tccd_pkg::EV_NOISE;
                    end else begin
                        o_state.pending = tccd_pkg::EV_TEMPO;
                    end
                    o_state.phase = tccd_pkg::PH_BYTE;
                end
            end
        endcase
    end

    always_comb begin
        o_event.kind       = kind;
        o_event.value      = value;
        o_event.shape      = shape;
        o_event.channel    = i_channel;
        o_event.row_end    = row_end;
        o_event.row_period = o_state.period;
    end

endmodule

`default_nettype wire

// File: rtl/tracker_channel_command_decoder_core.sv
`default_nettype none

// Per-channel decoder for tracker pattern command bytes. One byte is taken
// every cycle unless the input stalls, from any mix of channels. If the byte
// completes a command, its event passes from the decode stage to the output
// register. The accepting edge also loads the read register of the channel
// state memory. The edge on which the decode stage advances writes the decoded
// event into the output register and writes the updated channel state back.
// Consecutive bytes of the same channel are served by forwarding the write-back
// into the read register, so the rate stays at one byte per cycle while no
// stall holds the flow. The input stalls only when a byte waits in the decode
// stage while the output register holds a stalled event. Bytes tagged with a
// channel outside the configured count are consumed without any effect.
module tracker_channel_command_decoder_core #(
    parameter int CHANNELS = 3
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic [1:0]  i_channel,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [3:0]       o_event_kind,
    output logic [15:0]      o_event_value,
    output logic [3:0]       o_envelope_shape,
    output logic [1:0]       o_event_channel,
    output logic             o_row_end,
    output logic [4:0]       o_row_period
);

    localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    logic                  r_s1_valid;
    logic                  r_s1_in_range;
    logic [7:0]            r_s1_byte;
    logic [1:0]            r_s1_channel;
    logic                  r_out_valid;
    tccd_pkg::t_event      r_out_event;

    logic                  advance;
    logic                  in_accept;
    logic                  in_range;
    logic                  wr_en;
    logic [AW-1:0]         rd_idx;
    logic [AW-1:0]         wr_idx;
    tccd_pkg::t_chan_state cur_state;
    tccd_pkg::t_chan_state next_state;
    logic                  dec_emit;
    tccd_pkg::t_event      dec_event;

    assign advance   = !r_out_valid || !i_stall;
    assign o_stall   = r_s1_valid && !advance;
    assign in_accept = i_valid && !o_stall;
    assign in_range  = 32'(i_channel) < CHANNELS;
    assign rd_idx    = AW'(i_channel);
    assign wr_idx    = AW'(r_s1_channel);
    assign wr_en     = r_s1_valid && r_s1_in_range && advance;

    tccd_state_mem #(
        .CHANNELS (CHANNELS),
        .AW       (AW)
    ) u_state_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (in_accept && in_range),
        .i_rd_idx  (rd_idx),
        .i_wr_en   (wr_en),
        .i_wr_idx  (wr_idx),
        .i_wr_data (next_state),
        .o_rd_data (cur_state)
    );

    tccd_decode u_decode (
        .i_data_byte (r_s1_byte),
        .i_channel   (r_s1_channel),
        .i_state     (cur_state),
        .o_state     (next_state),
        .o_emit      (dec_emit),
        .o_event     (dec_event)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_accept) begin
            r_s1_valid <= 1'b1;
        end else if (advance) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_in_range <= in_range;
            r_s1_byte     <= i_data_byte;
            r_s1_channel  <= i_channel;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_s1_valid && r_s1_in_range && dec_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_event <= dec_event;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_event_kind     = r_out_event.kind;
    assign o_event_value    = r_out_event.value;
    assign o_envelope_shape = r_out_event.shape;
    assign o_event_channel  = r_out_event.channel;
    assign o_row_end        = r_out_event.row_end;
    assign o_row_period     = r_out_event.row_period;

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid set right after reset");

    a_row_end_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_row_end) |->
            (o_event_kind == tccd_pkg::EV_REST || o_event_kind == tccd_pkg::EV_NOTE
             || o_event_kind == tccd_pkg::EV_PERIOD))
        else $error("row end on an event that does not close a row");

    a_shape_only_envelope: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_envelope_shape != 4'h0) |-> (o_event_kind == tccd_pkg::EV_ENVELOPE))
        else $error("envelope shape on a non-envelope event");

    a_stall_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_s1_valid && r_out_valid && i_stall))
        else $error("input stalled without a blocked transaction");

endmodule

`default_nettype wire

// File: verif/testbench.sv
`timescale 1ns / 1ps

module testbench;

    localparam int NUM_CHANNELS = 3;
    localparam int RANDOM_ITEMS = 1050;
    localparam int QUIET_TAIL   = 150;
    localparam int CYCLE_LIMIT  = 400000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic [7:0]  i_data_byte = 8'h00;
    logic [1:0]  i_channel = 2'd0;
    logic        i_stall = 1'b0;
    logic        o_stall;
    logic        o_valid;
    logic [3:0]  o_event_kind;
    logic [15:0] o_event_value;
    logic [3:0]  o_envelope_shape;
    logic [1:0]  o_event_channel;
    logic        o_row_end;
    logic [4:0]  o_row_period;

    bit tx_idle_on = 1'b1;
    bit rx_idle_on = 1'b1;
    int cycle_count = 0;

    tracker_channel_command_decoder_core #(
        .CHANNELS(NUM_CHANNELS)
    ) u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_data_byte     (i_data_byte),
        .i_channel       (i_channel),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_event_kind    (o_event_kind),
        .o_event_value   (o_event_value),
        .o_envelope_shape(o_envelope_shape),
        .o_event_channel (o_event_channel),
        .o_row_end       (o_row_end),
        .o_row_period    (o_row_period)
    );

    class event_scoreboard;
        tccd_pkg::t_phase      phase[NUM_CHANNELS];
        tccd_pkg::t_event_kind pending[NUM_CHANNELS];
        logic [7:0]            low_byte[NUM_CHANNELS];
        logic [3:0]            env_type[NUM_CHANNELS];
        logic [4:0]            period[NUM_CHANNELS];
        tccd_pkg::t_event      expected_events[$];
        int                    errors;

        function new();
            errors = 0;
            for (int i = 0; i < NUM_CHANNELS; i++) begin
                phase[i]    = tccd_pkg::PH_OPCODE;
                pending[i]  = tccd_pkg::EV_SAMPLE;
                low_byte[i] = 8'h00;
                env_type[i] = 4'h0;
                period[i]   = 5'd0;
            end
        endfunction

        task report(string msg);
            $display("MISMATCH at %0t: %s", $realtime, msg);
            errors++;
        endtask

        // Advances one channel's parser and returns 1 when the byte completes a command.
        function bit decode_byte(logic [7:0] b, logic [1:0] c, output tccd_pkg::t_event ev);
            ev = '0;
            ev.channel = c;
            if (c >= NUM_CHANNELS)
                return 1'b0;
            case (phase[c])
                tccd_pkg::PH_WORD_LO: begin
                    low_byte[c] = b;
                    phase[c] = tccd_pkg::PH_WORD_HI;
                    return 1'b0;
                end
                tccd_pkg::PH_WORD_HI: begin
                    ev.kind  = pending[c];
                    ev.value = {b, low_byte[c]};
                    ev.shape = (pending[c] == tccd_pkg::EV_ENVELOPE) ? env_type[c] : 4'h0;
                    phase[c] = tccd_pkg::PH_OPCODE;
                end
                tccd_pkg::PH_BYTE: begin
                    ev.kind  = (pending[c] == tccd_pkg::EV_TEMPO && b < tccd_pkg::TEMPO_LOWEST) ?
                               tccd_pkg::EV_TEMPO_ERR : pending[c];
                    ev.value = 16'(b);
                    phase[c] = tccd_pkg::PH_OPCODE;
                end
                default: begin
                    if (b <= tccd_pkg::OP_SAMPLE_LAST) begin
                        ev.kind  = tccd_pkg::EV_SAMPLE;
                        ev.value = 16'(b);
                    end else if (b <= tccd_pkg::OP_VOLUME_LAST) begin
                        ev.kind  = tccd_pkg::EV_VOLUME;
                        ev.value = 16'(b - tccd_pkg::OP_VOLUME_FIRST);
                    end else if (b == tccd_pkg::OP_REST) begin
                        period[c]  = 5'd0;
                        ev.kind    = tccd_pkg::EV_REST;
                        ev.row_end = 1'b1;
                    end else if (b <= tccd_pkg::OP_ENV_LAST) begin
                        env_type[c] = 4'(b - tccd_pkg::OP_REST);
                        pending[c]  = tccd_pkg::EV_ENVELOPE;
                        phase[c]    = tccd_pkg::PH_WORD_LO;
                        return 1'b0;
                    end else if (b == tccd_pkg::OP_NOENV) begin
                        ev.kind = tccd_pkg::EV_NOENV;
                    end else if (b <= tccd_pkg::OP_PERIOD_LAST) begin
                        period[c]  = 5'(b - tccd_pkg::OP_PERIOD_FIRST);
                        ev.kind    = tccd_pkg::EV_PERIOD;
                        ev.value   = 16'(b - tccd_pkg::OP_PERIOD_FIRST);
                        ev.row_end = 1'b1;
                    end else if (b <= tccd_pkg::OP_NOTE_LAST) begin
                        period[c]  = 5'd0;
                        ev.kind    = tccd_pkg::EV_NOTE;
                        ev.value   = 16'(b - tccd_pkg::OP_NOTE_FIRST);
                        ev.row_end = 1'b1;
                    end else if (b <= tccd_pkg::OP_ORN_LAST) begin
                        ev.kind  = tccd_pkg::EV_ORNAMENT;
                        ev.value = 16'(b - tccd_pkg::OP_ORN_FIRST);
                    end else if (b == tccd_pkg::OP_SLIDE) begin
                        pending[c] = tccd_pkg::EV_SLIDE;
                        phase[c]   = tccd_pkg::PH_WORD_LO;
                        return 1'b0;
                    end else begin
                        pending[c] = (b == tccd_pkg::OP_NOTESLIDE) ? tccd_pkg::EV_NOTESLIDE :
                                     (b == tccd_pkg::OP_NOISE)     ? tccd_pkg::EV_NOISE :
                                                                     tccd_pkg::EV_TEMPO;
                        phase[c]   = tccd_pkg::PH_BYTE;
                        return 1'b0;
                    end
                end
            endcase
            ev.row_period = period[c];
            return 1'b1;
        endfunction

        function void note_transaction(logic [7:0] b, logic [1:0] c);
            tccd_pkg::t_event ev;
            if (decode_byte(b, c, ev))
                expected_events = {expected_events, ev};
        endfunction

        task check_event(tccd_pkg::t_event got);
            tccd_pkg::t_event want;
            if (expected_events.size() == 0) begin
                report($sformatf("unexpected event kind %0d value %h on channel %0d",
                                 got.kind, got.value, got.channel));
                return;
            end
            want = expected_events.pop_front();
            if (got.kind != want.kind)
                report($sformatf("kind %0d, expected %0d", got.kind, want.kind));
            if (got.value != want.value)
                report($sformatf("value %h, expected %h", got.value, want.value));
            if (got.shape != want.shape)
                report($sformatf("envelope shape %0d, expected %0d", got.shape, want.shape));
            if (got.channel != want.channel)
                report($sformatf("channel %0d, expected %0d", got.channel, want.channel));
            if (got.row_end != want.row_end)
                report($sformatf("row end %0b, expected %0b", got.row_end, want.row_end));
            if (got.row_period != want.row_period)
                report($sformatf("row period %0d, expected %0d",
                                 got.row_period, want.row_period));
        endtask
    endclass

    event_scoreboard scoreboard = new();

    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            scoreboard.check_event('{
                kind:       tccd_pkg::t_event_kind'(o_event_kind),
                value:      o_event_value,
                shape:      o_envelope_shape,
                channel:    o_event_channel,
                row_end:    o_row_end,
                row_period: o_row_period
            });
        end
    end

    // Receiver back-pressure in bursts.
    initial begin
        int gap;
        forever begin
            @(negedge i_clk);
            if (rx_idle_on && $urandom_range(0, 7) == 0) begin
                gap = $urandom_range(1, 15);
                i_stall <= 1'b1;
                repeat (gap) @(negedge i_clk);
                i_stall <= 1'b0;
            end
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic [1:0] c);
        int gap;
        @(negedge i_clk);
        if (tx_idle_on && $urandom_range(0, 7) == 0) begin
            gap = $urandom_range(1, 15);
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid     <= 1'b1;
        i_data_byte <= b;
        i_channel   <= c;
        @(posedge i_clk);
        while (o_stall)
            @(posedge i_clk);
        scoreboard.note_transaction(b, c);
    endtask

    function automatic logic [7:0] any_operand();
        case ($urandom_range(0, 5))
            0: return 8'h00;
            1: return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    // Builds the byte sequence of one random command for a single channel.
    function automatic void build_command(output logic [7:0] q[$]);
        tccd_pkg::t_event_kind pick;
        pick = tccd_pkg::t_event_kind'($urandom_range(0, 12));
        q = {};
        case (pick)
            tccd_pkg::EV_SAMPLE:
                q = {8'($urandom_range(0, tccd_pkg::OP_SAMPLE_LAST))};
            tccd_pkg::EV_VOLUME:
                q = {8'($urandom_range(tccd_pkg::OP_VOLUME_FIRST, tccd_pkg::OP_VOLUME_LAST))};
            tccd_pkg::EV_REST:
                q = {tccd_pkg::OP_REST};
            tccd_pkg::EV_ENVELOPE: begin
                q = {8'($urandom_range(tccd_pkg::OP_REST + 1, tccd_pkg::OP_ENV_LAST))};
                q = {q, any_operand()};
                q = {q, any_operand()};
            end
            tccd_pkg::EV_NOENV:
                q = {tccd_pkg::OP_NOENV};
            tccd_pkg::EV_PERIOD:
                q = {8'($urandom_range(tccd_pkg::OP_PERIOD_FIRST, tccd_pkg::OP_PERIOD_LAST))};
            tccd_pkg::EV_NOTE:
                q = {8'($urandom_range(tccd_pkg::OP_NOTE_FIRST, tccd_pkg::OP_NOTE_LAST))};
            tccd_pkg::EV_ORNAMENT:
                q = {8'($urandom_range(tccd_pkg::OP_ORN_FIRST, tccd_pkg::OP_ORN_LAST))};
            tccd_pkg::EV_SLIDE: begin
                q = {tccd_pkg::OP_SLIDE};
                q = {q, any_operand()};
                q = {q, any_operand()};
            end
            tccd_pkg::EV_NOTESLIDE: begin
                q = {tccd_pkg::OP_NOTESLIDE};
                q = {q, any_operand()};
            end
            tccd_pkg::EV_NOISE: begin
                q = {tccd_pkg::OP_NOISE};
                q = {q, any_operand()};
            end
            tccd_pkg::EV_TEMPO: begin
                q = {8'($urandom_range(tccd_pkg::OP_NOISE + 1, 255))};
                // Bias toward the boundary so that rejected tempos show up often.
                if ($urandom_range(0, 2) == 0)
                    q = {q, 8'($urandom_range(0, tccd_pkg::TEMPO_LOWEST))};
                else
                    q = {q, any_operand()};
            end
            default:
                q = {8'($urandom)};
        endcase
    endfunction

    initial begin
        logic [9:0] directed[];
        logic [7:0] stream_bytes[NUM_CHANNELS][$];
        logic [7:0] cmd[$];
        int         sent;
        int         c;

        directed = '{
            10'h000, 10'h01F, 10'h020, 10'h02F, 10'h030,
            10'h131, 10'h230, 10'h100, 10'h100,
            10'h23E, 10'h2FF, 10'h2FF,
            10'h03F, 10'h040, 10'h05F, 10'h060, 10'h0CB, 10'h0CC, 10'h0EC,
            10'h1ED, 10'h134, 10'h112,
            10'h2EE, 10'h2FF, 10'h0EF, 10'h000, 10'h3A5,
            10'h1F0, 10'h102, 10'h2FF, 10'h203
        };

        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part: each opcode range at its edges, both word operands,
        // interleaved channels, an ignored channel and both sides of the tempo limit.
        foreach (directed[i])
            send_byte(directed[i][7:0], directed[i][9:8]);

        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            if (sent >= RANDOM_ITEMS - QUIET_TAIL) begin
                tx_idle_on = 1'b0;
                rx_idle_on = 1'b0;
            end
            if ($urandom_range(0, 39) == 0) begin
                send_byte(8'($urandom), 2'd3);
            end else begin
                c = $urandom_range(0, NUM_CHANNELS - 1);
                if (stream_bytes[c].size() == 0) begin
                    build_command(cmd);
                    stream_bytes[c] = cmd;
                end
                send_byte(stream_bytes[c].pop_front(), 2'(c));
                sent++;
            end
        end

        @(negedge i_clk);
        i_valid <= 1'b0;
        while (scoreboard.expected_events.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        if (scoreboard.errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// File: filelist.f
rtl/tccd_pkg.sv
rtl/tccd_state_mem.sv
rtl/tccd_decode.sv
rtl/tracker_channel_command_decoder_core.sv
verif/testbench.sv
